FILE: rtl/core/tcma_pkg.sv
// shared types and constants for the tetrahedron mass matrix assembly block
package tcma_pkg;

  // item kinds carried in the input tuser
  localparam logic [2:0] MODE_COORD  = 3'd0;
  localparam logic [2:0] MODE_ROWPTR = 3'd1;
  localparam logic [2:0] MODE_COLIDX = 3'd2;
  localparam logic [2:0] MODE_ELEM   = 3'd3;
  localparam logic [2:0] MODE_WRVAL  = 3'd4;
  localparam logic [2:0] MODE_RDVAL  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  // coordinate width and derived arithmetic sizes
  localparam int COORD_BITS = 16;
  localparam int TERM_COUNT = 24;
  localparam int MUL_STEPS  = TERM_COUNT + 2;
  localparam int DIAG_DIV   = 60;
  localparam int OFF_DIV    = 120;

  // constant division in 16-bit digits, each digit by reciprocal multiplication
  // partial remainder and digit stay below 2^23, so ceil(2^s / d) is exact there
  localparam int          DIV_CHUNK  = 16;
  localparam int          DIV_STEPS  = 4;
  localparam logic [23:0] DIV_RECIP  = 24'd8947849;
  localparam int          DIAG_SHIFT = 29;
  localparam int          OFF_SHIFT  = 30;

  // triple product terms {negate, x vertex, y vertex, z vertex}
  localparam logic [6:0] TERM_TAB [TERM_COUNT] = '{
    {1'b0, 2'd0, 2'd1, 2'd3}, {1'b0, 2'd0, 2'd2, 2'd1}, {1'b0, 2'd0, 2'd3, 2'd2},
    {1'b0, 2'd1, 2'd0, 2'd2}, {1'b0, 2'd1, 2'd2, 2'd3}, {1'b0, 2'd1, 2'd3, 2'd0},
    {1'b0, 2'd2, 2'd0, 2'd3}, {1'b0, 2'd2, 2'd1, 2'd0}, {1'b0, 2'd2, 2'd3, 2'd1},
    {1'b0, 2'd3, 2'd0, 2'd1}, {1'b0, 2'd3, 2'd1, 2'd2}, {1'b0, 2'd3, 2'd2, 2'd0},
    {1'b1, 2'd0, 2'd1, 2'd2}, {1'b1, 2'd0, 2'd2, 2'd3}, {1'b1, 2'd0, 2'd3, 2'd1},
    {1'b1, 2'd1, 2'd0, 2'd3}, {1'b1, 2'd1, 2'd3, 2'd2}, {1'b1, 2'd1, 2'd2, 2'd0},
    {1'b1, 2'd2, 2'd0, 2'd1}, {1'b1, 2'd2, 2'd3, 2'd0}, {1'b1, 2'd2, 2'd1, 2'd3},
    {1'b1, 2'd3, 2'd0, 2'd2}, {1'b1, 2'd3, 2'd2, 2'd1}, {1'b1, 2'd3, 2'd1, 2'd0}
  };

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic dispatch;
    logic rd_take;
    logic crd_take;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic row_hi;
    logic row_set;
    logic scan_step;
    logic chk_issue;
    logic chk_take;
    logic next_j;
    logic el_fin;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] mode;
    logic       v_last;
    logic       mul_last;
    logic       div_last;
    logic       scan_done;
    logic       in_range;
    logic       j_last;
    logic       i_last;
  } stat_t;

endpackage

FILE: rtl/core/tet4_consistent_mass_csr_assembly.sv
// top level: stream ports, result register, controller and datapath
// load and value-write items write their store, then emit a result; a value read emits the entry
// an element does coordinate reads, 26 multiply steps and 4 divide steps, then for each
// of its four rows the row bound reads, the column scan and the entry read-modify-write;
// one item is in work at a time
// rst is synchronous and clears control state; stores hold nothing defined until loaded
module tet4_consistent_mass_csr_assembly import tcma_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int NONZERO_COUNT = 16384
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address, coord_x, coord_y, coord_z, word, value_in, node_0..node_3, zero pad
  input  logic [183:0] s_axis_tdata,
  // mode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_value
  output logic [63:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  cmd_t        cmd;
  stat_t       stat;
  logic        emit;
  logic        out_free;
  logic [63:0] res_value;
  logic [1:0]  res_status;

  // result register frees when taken
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= res_status;
    end
  end

  tcma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .emit     (emit),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcma_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .NONZERO_COUNT (NONZERO_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (s_axis_tuser),
    .address    (s_axis_tdata[14:0]),
    .coord_x    (s_axis_tdata[30:15]),
    .coord_y    (s_axis_tdata[46:31]),
    .coord_z    (s_axis_tdata[62:47]),
    .word       (s_axis_tdata[77:63]),
    .value_in   (s_axis_tdata[141:78]),
    .node_0     (s_axis_tdata[151:142]),
    .node_1     (s_axis_tdata[161:152]),
    .node_2     (s_axis_tdata[171:162]),
    .node_3     (s_axis_tdata[181:172]),
    .res_value  (res_value),
    .res_status (res_status)
  );

endmodule

FILE: rtl/core/tcma_dp.sv
// datapath: stores, triple product accumulator, rounding dividers and row update
module tcma_dp import tcma_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int NONZERO_COUNT = 16384
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic [2:0]                   mode,
  input  logic [14:0]                  address,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [14:0]                  word,
  input  logic [63:0]                  value_in,
  input  logic [9:0]                   node_0,
  input  logic [9:0]                   node_1,
  input  logic [9:0]                   node_2,
  input  logic [9:0]                   node_3,
  output logic [63:0]                  res_value,
  output logic [1:0]                   res_status
);

  localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int RS_W   = $clog2(NODE_COUNT + 1);
  localparam int NZ_W   = (NONZERO_COUNT > 1) ? $clog2(NONZERO_COUNT) : 1;
  localparam int NZP_W  = NZ_W + 1;

  // node index taken modulo the node count by shifted subtraction
  function automatic logic [9:0] node_mod(input logic [9:0] v);
    logic [9:0]  r;
    logic [31:0] lim;
    r = v;
    for (int k = 9; k >= 0; k--) begin
      lim = 32'(NODE_COUNT) << k;
      if (lim < 32'd1024 && {22'd0, r} >= lim) r = r - lim[9:0];
    end
    return r;
  endfunction

  // row start bound clamped to the nonzero count
  function automatic logic [NZP_W-1:0] clamp_rs(input logic [14:0] r);
    if (32'(r) > 32'(NONZERO_COUNT)) return NZP_W'(NONZERO_COUNT);
    return NZP_W'(r);
  endfunction

  logic [2:0]                   mode_r;
  logic [14:0]                  addr_r;
  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic [14:0]                  word_r;
  logic [63:0]                  val_r;
  logic [9:0]                   nodes [4];

  logic [1:0] v, i, j;
  logic [4:0] t;
  logic       missing, sat;

  logic signed [COORD_BITS-1:0] cx [4];
  logic signed [COORD_BITS-1:0] cy [4];
  logic signed [COORD_BITS-1:0] cz [4];
  logic signed [31:0]           p1;
  logic signed [47:0]           p2;
  logic [1:0]                   c1;
  logic                         s1, s2;
  logic signed [63:0]           acc;

  logic        neg_r;
  logic [63:0] num_a, num_b, q_a, q_b;
  logic [6:0]  rem_a, rem_b;
  logic [1:0]  dcnt;
  logic [63:0] diag, off;

  logic [NZP_W-1:0] row_s, row_e, k;
  logic             pend;
  logic [NZP_W-1:0] cnt [4];

  logic [3*COORD_BITS-1:0] crd_mem [NODE_COUNT];
  logic [14:0]             rs_mem  [NODE_COUNT + 1];
  logic [9:0]              col_mem [NONZERO_COUNT];
  logic [63:0]             ent_mem [NONZERO_COUNT];
  logic [3*COORD_BITS-1:0] crd_q;
  logic [14:0]             rs_q;
  logic [9:0]              col_q;
  logic [63:0]             ent_q;

  logic                 node_ok, rs_ok, nz_ok;
  logic [NZP_W-1:0]     len, pos;
  logic [RS_W-1:0]      rs_ra;
  logic [NZ_W-1:0]      col_ra, ent_ra, ent_wa;
  logic                 ent_we, hit;
  logic [63:0]          ent_wd, add_b, sum;
  logic                 ovf;
  logic [6:0]           term;
  logic [63:0]          mag;
  logic [22:0]          pd_a, pd_b, qm_a, qm_b, rm_a, rm_b;
  logic [46:0]          pr_a, pr_b;
  logic [DIV_CHUNK-1:0] qd_a, qd_b;
  logic [NZP_W-1:0]     e_clamp;

  // address checks for load and read items
  assign node_ok = 32'(addr_r) < 32'(NODE_COUNT);
  assign rs_ok   = 32'(addr_r) <= 32'(NODE_COUNT);
  assign nz_ok   = 32'(addr_r) < 32'(NONZERO_COUNT);

  // row position of the wanted column
  assign len = row_e - row_s;
  assign pos = row_s + cnt[j];

  // read addresses
  assign rs_ra  = RS_W'(nodes[i]) + RS_W'(cmd.row_hi);
  assign col_ra = cmd.chk_issue ? NZ_W'(pos) : NZ_W'(k);
  assign ent_ra = cmd.chk_issue ? NZ_W'(pos) : NZ_W'(addr_r);

  // saturating add into the found entry
  assign hit   = col_q == nodes[j];
  assign add_b = (i == j) ? diag : off;
  assign sum   = ent_q + add_b;
  assign ovf   = (ent_q[63] == add_b[63]) && (sum[63] != ent_q[63]);

  always_comb begin
    ent_we = 1'b0;
    ent_wa = NZ_W'(addr_r);
    ent_wd = val_r;
    if (cmd.dispatch && mode_r == MODE_WRVAL && nz_ok) begin
      ent_we = 1'b1;
    end else if (cmd.chk_take && hit) begin
      ent_we = 1'b1;
      ent_wa = NZ_W'(pos);
      if (ovf) ent_wd = add_b[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else ent_wd = sum;
    end
  end

  // memories with registered read data
  always_ff @(posedge clk) begin
    if (cmd.dispatch && mode_r == MODE_COORD && node_ok)
      crd_mem[NODE_W'(addr_r)] <= {z_r, y_r, x_r};
    crd_q <= crd_mem[NODE_W'(nodes[v])];
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch && mode_r == MODE_ROWPTR && rs_ok)
      rs_mem[RS_W'(addr_r)] <= word_r;
    rs_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch && mode_r == MODE_COLIDX && nz_ok)
      col_mem[NZ_W'(addr_r)] <= word_r[9:0];
    col_q <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_q <= ent_mem[ent_ra];
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= mode;
      addr_r   <= address;
      x_r      <= coord_x;
      y_r      <= coord_y;
      z_r      <= coord_z;
      word_r   <= word;
      val_r    <= value_in;
      nodes[0] <= node_mod(node_0);
      nodes[1] <= node_mod(node_1);
      nodes[2] <= node_mod(node_2);
      nodes[3] <= node_mod(node_3);
    end
  end

  // sequencing counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      i       <= '0;
      j       <= '0;
      t       <= '0;
      missing <= 1'b0;
      sat     <= 1'b0;
    end else if (cmd.capture) begin
      v       <= '0;
      i       <= '0;
      j       <= '0;
      t       <= '0;
      missing <= 1'b0;
      sat     <= 1'b0;
    end else begin
      if (cmd.crd_take) v <= v + 2'd1;
      if (cmd.mul_step) t <= t + 5'd1;
      if (cmd.next_j) begin
        j <= j + 2'd1;
        if (j == 2'd3) i <= i + 2'd1;
      end
      if (cmd.chk_issue && !(cnt[j] < len)) missing <= 1'b1;
      if (cmd.chk_take && !hit) missing <= 1'b1;
      if (cmd.chk_take && hit && ovf) sat <= 1'b1;
    end
  end

  // vertex coordinates
  always_ff @(posedge clk) begin
    if (cmd.crd_take) begin
      cx[v] <= crd_q[COORD_BITS-1:0];
      cy[v] <= crd_q[2*COORD_BITS-1:COORD_BITS];
      cz[v] <= crd_q[3*COORD_BITS-1:2*COORD_BITS];
    end
  end

  // three-stage triple product and signed accumulation, one term per cycle
  assign term = TERM_TAB[(t < 5'(TERM_COUNT)) ? t : 5'd0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (cmd.mul_step) begin
      if (t < 5'(TERM_COUNT)) begin
        p1 <= cx[term[5:4]] * cy[term[3:2]];
        c1 <= term[1:0];
        s1 <= term[6];
      end
      if (t >= 5'd1 && t <= 5'(TERM_COUNT)) begin
        p2 <= p1 * cz[c1];
        s2 <= s1;
      end
      if (t >= 5'd2) acc <= acc + (s2 ? -64'(p2) : 64'(p2));
    end
  end

  // two constant dividers, one 16-bit quotient digit per cycle each
  assign mag  = acc[63] ? -acc : acc;
  assign pd_a = {rem_a, num_a[63 -: DIV_CHUNK]};
  assign pd_b = {rem_b, num_b[63 -: DIV_CHUNK]};
  assign pr_a = 47'(pd_a) * 47'(DIV_RECIP);
  assign pr_b = 47'(pd_b) * 47'(DIV_RECIP);
  assign qd_a = pr_a[DIAG_SHIFT +: DIV_CHUNK];
  assign qd_b = pr_b[OFF_SHIFT +: DIV_CHUNK];
  assign qm_a = 23'(qd_a) * 23'(DIAG_DIV);
  assign qm_b = 23'(qd_b) * 23'(OFF_DIV);
  assign rm_a = pd_a - qm_a;
  assign rm_b = pd_b - qm_b;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r <= acc[63];
      num_a <= mag + 64'(DIAG_DIV / 2);
      num_b <= mag + 64'(OFF_DIV / 2);
      rem_a <= '0;
      rem_b <= '0;
      q_a   <= '0;
      q_b   <= '0;
      dcnt  <= '0;
    end else if (cmd.div_step) begin
      rem_a <= rm_a[6:0];
      rem_b <= rm_b[6:0];
      q_a   <= {q_a[63-DIV_CHUNK:0], qd_a};
      q_b   <= {q_b[63-DIV_CHUNK:0], qd_b};
      num_a <= {num_a[63-DIV_CHUNK:0], {DIV_CHUNK{1'b0}}};
      num_b <= {num_b[63-DIV_CHUNK:0], {DIV_CHUNK{1'b0}}};
      dcnt  <= dcnt + 2'd1;
    end
    if (cmd.div_fin) begin
      diag <= neg_r ? -q_a : q_a;
      off  <= neg_r ? -q_b : q_b;
    end
  end

  // row bounds and column scan counting smaller entries for all four columns
  assign e_clamp = clamp_rs(rs_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.row_set) begin
      pend <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= k < row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_hi) row_s <= clamp_rs(rs_q);
    if (cmd.row_set) begin
      row_e <= (e_clamp < row_s) ? row_s : e_clamp;
      k     <= row_s;
      for (int n = 0; n < 4; n++) cnt[n] <= '0;
    end else if (cmd.scan_step) begin
      if (k < row_e) k <= k + NZP_W'(1);
      if (pend) begin
        for (int n = 0; n < 4; n++) begin
          if (col_q < nodes[n]) cnt[n] <= cnt[n] + NZP_W'(1);
        end
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_value  <= '0;
      res_status <= ST_OK;
    end else if (cmd.rd_take) begin
      res_value <= nz_ok ? ent_q : 64'd0;
    end else if (cmd.el_fin) begin
      res_status <= missing ? ST_MISSING : (sat ? ST_SAT : ST_OK);
    end
  end

  // status to the controller
  assign stat.mode      = mode_r;
  assign stat.v_last    = v == 2'd3;
  assign stat.mul_last  = t == 5'(MUL_STEPS - 1);
  assign stat.div_last  = dcnt == 2'(DIV_STEPS - 1);
  assign stat.scan_done = (k == row_e) && !pend;
  assign stat.in_range  = cnt[j] < len;
  assign stat.j_last    = j == 2'd3;
  assign stat.i_last    = i == 2'd3;

endmodule

FILE: rtl/core/tcma_ctrl.sv
// controller state machine sequencing one item at a time through the datapath
module tcma_ctrl import tcma_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  out_free,
  output logic  emit,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_RD_TAK   = 5'd2;
  localparam logic [4:0] S_CRD_WAIT = 5'd3;
  localparam logic [4:0] S_CRD_TAK  = 5'd4;
  localparam logic [4:0] S_MUL      = 5'd5;
  localparam logic [4:0] S_DIV_INIT = 5'd6;
  localparam logic [4:0] S_DIV      = 5'd7;
  localparam logic [4:0] S_DIV_FIN  = 5'd8;
  localparam logic [4:0] S_ROW_LO   = 5'd9;
  localparam logic [4:0] S_ROW_HI   = 5'd10;
  localparam logic [4:0] S_ROW_SET  = 5'd11;
  localparam logic [4:0] S_SCAN     = 5'd12;
  localparam logic [4:0] S_CHK_ISS  = 5'd13;
  localparam logic [4:0] S_CHK_TAK  = 5'd14;
  localparam logic [4:0] S_EL_FIN   = 5'd15;
  localparam logic [4:0] S_FINISH   = 5'd16;

  logic [4:0] state, state_next;
  logic [4:0] after_j;

  // where to go once a column is done
  assign after_j = stat.j_last ? (stat.i_last ? S_EL_FIN : S_ROW_LO) : S_CHK_ISS;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    emit       = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        if (stat.mode == MODE_RDVAL) state_next = S_RD_TAK;
        else if (stat.mode == MODE_ELEM) state_next = S_CRD_WAIT;
        else state_next = S_FINISH;
      end
      S_RD_TAK: begin
        cmd.rd_take = 1'b1;
        state_next  = S_FINISH;
      end
      S_CRD_WAIT: state_next = S_CRD_TAK;
      S_CRD_TAK: begin
        cmd.crd_take = 1'b1;
        state_next   = stat.v_last ? S_MUL : S_CRD_WAIT;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_DIV_FIN;
      end
      S_DIV_FIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_ROW_LO;
      end
      S_ROW_LO: state_next = S_ROW_HI;
      S_ROW_HI: begin
        cmd.row_hi = 1'b1;
        state_next = S_ROW_SET;
      end
      S_ROW_SET: begin
        cmd.row_set = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_CHK_ISS;
        else cmd.scan_step = 1'b1;
      end
      S_CHK_ISS: begin
        cmd.chk_issue = 1'b1;
        if (stat.in_range) begin
          state_next = S_CHK_TAK;
        end else begin
          cmd.next_j = 1'b1;
          state_next = after_j;
        end
      end
      S_CHK_TAK: begin
        cmd.chk_take = 1'b1;
        cmd.next_j   = 1'b1;
        state_next   = after_j;
      end
      S_EL_FIN: begin
        cmd.el_fin = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
